@@ hw/rtl/ordat_pkg.sv @@
// Shared types and codes for the ordered array table.
// Item structs, request codes and status codes; no dependencies.
`timescale 1ns / 1ps

package ordat_pkg;

  // Request codes
  localparam logic [3:0] REQ_ADD_FIRST = 4'd0;
  localparam logic [3:0] REQ_ADD_LAST  = 4'd1;
  localparam logic [3:0] REQ_INSERT_AT = 4'd2;
  localparam logic [3:0] REQ_DEL_FIRST = 4'd3;
  localparam logic [3:0] REQ_DEL_LAST  = 4'd4;
  localparam logic [3:0] REQ_DEL_VALUE = 4'd5;
  localparam logic [3:0] REQ_DEL_AT    = 4'd6;
  localparam logic [3:0] REQ_CONTAINS  = 4'd7;
  localparam logic [3:0] REQ_READ      = 4'd8;
  localparam logic [3:0] REQ_SWAP      = 4'd9;
  localparam logic [3:0] REQ_CLEAR     = 4'd10;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] value;
    logic [6:0]         position;
    logic [5:0]         other_position;
  } ordat_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         found_index;
    logic signed [31:0] read_word;
    logic [6:0]         entry_count;
  } ordat_out_t;

endpackage

@@ hw/rtl/ordat_ram.sv @@
// Entry storage: one write port, one read port, registered read data.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module ordat_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/ordat_seq.sv @@
// Request sequencer: range checks, search and shift walks over the entry RAM.
// Uses ordat_pkg; drives the ports of ordat_ram.
`timescale 1ns / 1ps

module ordat_seq
  import ordat_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_ready,
  input  ordat_in_t     req_item,
  output logic          res_valid,
  input  logic          res_take,
  output ordat_out_t    res_item,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [31:0]   mem_wdata,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  logic [31:0]   mem_rdata
);

  localparam int WW = (CW > 7) ? CW : 7;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_SCAN, S_UP, S_PUT, S_DOWN, S_RDW, S_SWA, S_SWB, S_SWC, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  ordat_in_t       req_r, req_nxt;
  logic [AW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   pa_r, pa_nxt;
  logic [AW-1:0]   at_r, at_nxt;
  logic [31:0]     hold_r, hold_nxt;
  logic [2:0]      status_r, status_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [31:0]     rd_r, rd_nxt;

  logic [WW-1:0]   count_w, pos_w, pos2_w, at_w, del_w;
  logic            full, empty;

  assign count_w = WW'(count_r);
  assign pos_w   = WW'(req_r.position);
  assign pos2_w  = WW'(req_r.other_position);
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);

  // Insert index for the add requests
  always_comb begin
    unique case (req_r.req_type)
      REQ_ADD_FIRST: at_w = '0;
      REQ_ADD_LAST:  at_w = count_w;
      default:       at_w = pos_w;
    endcase
  end

  // Delete index for the positional delete requests
  always_comb begin
    unique case (req_r.req_type)
      REQ_DEL_FIRST: del_w = '0;
      REQ_DEL_LAST:  del_w = count_w - WW'(1);
      default:       del_w = pos_w;
    endcase
  end

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res_item.status      = status_r;
    res_item.found_index = 6'(idx_r);
    res_item.read_word   = rd_r;
    res_item.entry_count = 7'(count_r);
  end

  // Next-state logic and RAM control
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    req_nxt    = req_r;
    ptr_nxt    = ptr_r;
    left_nxt   = left_r;
    pend_nxt   = 1'b0;
    pa_nxt     = pa_r;
    at_nxt     = at_r;
    hold_nxt   = hold_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    rd_nxt     = rd_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          req_nxt    = req_item;
          status_nxt = ST_OK;
          idx_nxt    = '0;
          rd_nxt     = '0;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (req_r.req_type)
          REQ_ADD_FIRST, REQ_ADD_LAST, REQ_INSERT_AT: begin
            if (full) begin
              status_nxt = ST_FULL;
            end else if (at_w > count_w) begin
              status_nxt = ST_RANGE;
            end else begin
              // Walk from the last entry down to the insert index
              at_nxt    = AW'(at_w);
              left_nxt  = CW'(count_w - at_w);
              ptr_nxt   = AW'(count_w - WW'(1));
              state_nxt = S_UP;
            end
          end
          REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_AT: begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end else if (del_w >= count_w) begin
              status_nxt = ST_RANGE;
            end else begin
              idx_nxt   = AW'(del_w);
              left_nxt  = CW'(count_w - WW'(1) - del_w);
              ptr_nxt   = AW'(del_w + WW'(1));
              state_nxt = S_DOWN;
            end
          end
          REQ_DEL_VALUE, REQ_CONTAINS: begin
            if (empty && req_r.req_type == REQ_DEL_VALUE) begin
              status_nxt = ST_EMPTY;
            end else begin
              ptr_nxt   = '0;
              left_nxt  = count_r;
              state_nxt = S_SCAN;
            end
          end
          REQ_READ: begin
            if (pos_w >= count_w) begin
              status_nxt = ST_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(pos_w);
              state_nxt = S_RDW;
            end
          end
          REQ_SWAP: begin
            if (pos_w >= count_w || pos2_w >= count_w) begin
              status_nxt = ST_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(pos_w);
              state_nxt = S_SWA;
            end
          end
          REQ_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        if (pend_r && mem_rdata == req_r.value) begin
          // First match found
          idx_nxt = pa_r;
          if (req_r.req_type == REQ_DEL_VALUE) begin
            left_nxt  = CW'(count_w - WW'(1) - WW'(pa_r));
            ptr_nxt   = pa_r + AW'(1);
            state_nxt = S_DOWN;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (left_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r;
          pend_nxt  = 1'b1;
          pa_nxt    = ptr_r;
          ptr_nxt   = ptr_r + AW'(1);
          left_nxt  = left_r - CW'(1);
        end else if (!pend_r) begin
          status_nxt = ST_NOTFOUND;
          state_nxt  = S_DONE;
        end
      end

      S_UP: begin
        // Move each entry one place up
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pa_r + AW'(1);
          mem_wdata = mem_rdata;
        end
        if (left_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r;
          pend_nxt  = 1'b1;
          pa_nxt    = ptr_r;
          ptr_nxt   = ptr_r - AW'(1);
          left_nxt  = left_r - CW'(1);
        end else begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = at_r;
        mem_wdata = req_r.value;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_DOWN: begin
        // Move each entry one place down over the removed slot
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pa_r - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (left_r != '0) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r;
          pend_nxt  = 1'b1;
          pa_nxt    = ptr_r;
          ptr_nxt   = ptr_r + AW'(1);
          left_nxt  = left_r - CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_RDW: begin
        rd_nxt    = mem_rdata;
        state_nxt = S_DONE;
      end

      S_SWA: begin
        hold_nxt  = mem_rdata;
        mem_re    = 1'b1;
        mem_raddr = AW'(pos2_w);
        state_nxt = S_SWB;
      end

      S_SWB: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_w);
        mem_wdata = mem_rdata;
        state_nxt = S_SWC;
      end

      S_SWC: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos2_w);
        mem_wdata = hold_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, count and result fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    req_r    <= req_nxt;
    ptr_r    <= ptr_nxt;
    left_r   <= left_nxt;
    pa_r     <= pa_nxt;
    at_r     <= at_nxt;
    hold_r   <= hold_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    rd_r     <= rd_nxt;
  end

endmodule

@@ hw/rtl/ordered_array_table.sv @@
// Ordered array table: packed table of signed words with insert, delete,
// search, read, swap and clear requests.
//
// Input channel in_valid/in_ready/in_item carries one request item; output
// channel out_valid/out_ready/out_item returns one result item per request:
// status, found index, read word and entry count after the request.
// One request is worked on at a time. Clear, unknown codes and full, empty
// or index errors finish without touching the RAM; read and swap go through
// the RAM read port; add/insert at index a shifts the entries from a up by
// one, delete at index a shifts the entries after a down by one, and
// contains and delete by value scan from index 0 for the first match.
// The entry RAM has one read and one write port; the shift and search walks
// move one entry per cycle through it.
// A finished result sits in an output register, so the next request is
// accepted while the receiver stalls; that request then waits for the
// register to drain. Reset empties the table (count to zero); entry contents
// are not cleared and need no clearing pass.
// Uses ordat_pkg, ordat_seq and ordat_ram.
`timescale 1ns / 1ps

module ordered_array_table
  import ordat_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ordat_in_t  in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output ordat_out_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          res_valid;
  logic          res_take;
  ordat_out_t    res_item;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  logic          out_valid_r;
  ordat_out_t    out_item_r;

  ordat_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req_item  (in_item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_item  (res_item),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ordat_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register takes a result when empty or draining
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
    if (res_take && res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
